FILE: src/max_pool_and_upsample_2d_defines.svh
// Assertion macros for the max pool / upsample block.
// Included by the top level only; no other dependencies.
`ifndef MAX_POOL_AND_UPSAMPLE_2D_DEFINES_SVH
`define MAX_POOL_AND_UPSAMPLE_2D_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define MPU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every edge, reset included.
`define MPU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MPU_ASSERT(label, prop, msg)
`define MPU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/mpu_pkg.sv
// Shared types, constants and register helpers for the max pool / upsample block.
// No dependencies.
package mpu_pkg;

   localparam int MAX_EXTENT   = 1024;
   localparam int MAX_FACTOR   = 8;
   localparam int MAX_CHANNELS = 64;
   localparam int SAMPLE_W     = 16;

   localparam int EXT_W    = $clog2(MAX_EXTENT);        // coordinate width
   localparam int EXTC_W   = EXT_W + 1;                 // extent / count width
   localparam int CHAN_W   = $clog2(MAX_CHANNELS);
   localparam int CHANC_W  = CHAN_W + 1;
   localparam int FACTOR_W = 4;
   localparam int SUB_W    = $clog2(MAX_FACTOR);        // offset inside a window
   localparam int PMAX_W   = SAMPLE_W - 1;              // stored maxima are never negative
   localparam int CSR_W    = EXTC_W;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_EXTENT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_EXTENT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   localparam logic MODE_REDUCE  = 1'b0;
   localparam logic MODE_ENLARGE = 1'b1;

   // Configuration, already clamped to the legal range
   typedef struct packed {
      logic                mode;
      logic [FACTOR_W-1:0] factor;
      logic [EXTC_W-1:0]   outer_extent;
      logic [EXTC_W-1:0]   inner_extent;
      logic [CHANC_W-1:0]  channel_count;
   } cfg_type;

   // Position of the next input item and the flags derived from it
   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [EXT_W-1:0]  outer;
      logic [EXT_W-1:0]  inner;
      logic [EXT_W-1:0]  outer_win;
      logic [EXT_W-1:0]  inner_win;
      logic [EXT_W-1:0]  outer_base;
      logic [EXT_W-1:0]  inner_base;
      logic              first;
      logic              win_end;
   } pos_type;

   function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
      logic [FACTOR_W-1:0] r;
      r = v;
      if (v == '0)
         r = FACTOR_W'(1);
      else if (v > FACTOR_W'(MAX_FACTOR))
         r = FACTOR_W'(MAX_FACTOR);
      return r;
   endfunction

   function automatic logic [EXTC_W-1:0] clamp_extent(input logic [EXTC_W-1:0] v);
      logic [EXTC_W-1:0] r;
      r = v;
      if (v == '0)
         r = EXTC_W'(1);
      else if (v > EXTC_W'(MAX_EXTENT))
         r = EXTC_W'(MAX_EXTENT);
      return r;
   endfunction

   function automatic logic [CHANC_W-1:0] clamp_chan(input logic [CHANC_W-1:0] v);
      logic [CHANC_W-1:0] r;
      r = v;
      if (v == '0)
         r = CHANC_W'(1);
      else if (v > CHANC_W'(MAX_CHANNELS))
         r = CHANC_W'(MAX_CHANNELS);
      return r;
   endfunction

endpackage

FILE: src/mpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mpu_pos.sv
// Frame position tracker: channel / outer / inner counters plus window and
// block offsets, with window flags. Depends on mpu_pkg.
module mpu_pos (
   input  logic            clock,
   input  logic            reset,
   input  mpu_pkg::cfg_type cfg,
   input  logic            restart,
   input  logic            advance,
   output mpu_pkg::pos_type pos
);

   logic [mpu_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic [mpu_pkg::EXT_W-1:0]  outer_ff, outer_in, inner_ff, inner_in;
   logic [mpu_pkg::EXT_W-1:0]  outer_win_ff, outer_win_in, inner_win_ff, inner_win_in;
   logic [mpu_pkg::EXT_W-1:0]  outer_base_ff, outer_base_in, inner_base_ff, inner_base_in;
   logic [mpu_pkg::SUB_W-1:0]  outer_sub_ff, outer_sub_in, inner_sub_ff, inner_sub_in;

   logic [mpu_pkg::FACTOR_W-1:0] f_m1_full;
   logic [mpu_pkg::SUB_W-1:0]    f_m1;
   logic [mpu_pkg::EXTC_W-1:0]   outer_nx, inner_nx, outer_base_nx, inner_base_nx;
   logic [mpu_pkg::CHANC_W-1:0]  chan_nx;
   logic                         reduce, inner_wrap, outer_wrap, chan_wrap;
   logic                         inner_sub_end, outer_sub_end;

   always_comb begin
      f_m1_full     = cfg.factor - mpu_pkg::FACTOR_W'(1);
      f_m1          = f_m1_full[mpu_pkg::SUB_W-1:0];
      reduce        = (cfg.mode == mpu_pkg::MODE_REDUCE);
      outer_nx      = {1'b0, outer_ff} + mpu_pkg::EXTC_W'(1);
      inner_nx      = {1'b0, inner_ff} + mpu_pkg::EXTC_W'(1);
      outer_base_nx = {1'b0, outer_base_ff} + mpu_pkg::EXTC_W'(cfg.factor);
      inner_base_nx = {1'b0, inner_base_ff} + mpu_pkg::EXTC_W'(cfg.factor);
      chan_nx       = {1'b0, chan_ff} + mpu_pkg::CHANC_W'(1);
      inner_sub_end = (inner_sub_ff == f_m1);
      outer_sub_end = (outer_sub_ff == f_m1);
      // reduce walks the full frame, enlarge walks the small map
      inner_wrap = reduce ? (inner_nx >= cfg.inner_extent)
                          : (inner_base_nx >= cfg.inner_extent);
      outer_wrap = reduce ? (outer_nx >= cfg.outer_extent)
                          : (outer_base_nx >= cfg.outer_extent);
      chan_wrap  = (chan_nx >= cfg.channel_count);

      chan_in       = chan_ff;
      outer_in      = outer_ff;
      inner_in      = inner_ff;
      outer_win_in  = outer_win_ff;
      inner_win_in  = inner_win_ff;
      outer_base_in = outer_base_ff;
      inner_base_in = inner_base_ff;
      outer_sub_in  = outer_sub_ff;
      inner_sub_in  = inner_sub_ff;

      if (restart) begin
         chan_in       = '0;
         outer_in      = '0;
         inner_in      = '0;
         outer_win_in  = '0;
         inner_win_in  = '0;
         outer_base_in = '0;
         inner_base_in = '0;
         outer_sub_in  = '0;
         inner_sub_in  = '0;
      end else if (advance) begin
         if (!inner_wrap) begin
            inner_in      = inner_nx[mpu_pkg::EXT_W-1:0];
            inner_base_in = inner_base_nx[mpu_pkg::EXT_W-1:0];
            inner_sub_in  = inner_sub_end ? '0 : inner_sub_ff + mpu_pkg::SUB_W'(1);
            inner_win_in  = inner_win_ff + mpu_pkg::EXT_W'(inner_sub_end);
         end else begin
            inner_in      = '0;
            inner_base_in = '0;
            inner_sub_in  = '0;
            inner_win_in  = '0;
            if (!outer_wrap) begin
               outer_in      = outer_nx[mpu_pkg::EXT_W-1:0];
               outer_base_in = outer_base_nx[mpu_pkg::EXT_W-1:0];
               outer_sub_in  = outer_sub_end ? '0 : outer_sub_ff + mpu_pkg::SUB_W'(1);
               outer_win_in  = outer_win_ff + mpu_pkg::EXT_W'(outer_sub_end);
            end else begin
               outer_in      = '0;
               outer_base_in = '0;
               outer_sub_in  = '0;
               outer_win_in  = '0;
               chan_in       = chan_wrap ? '0 : chan_nx[mpu_pkg::CHAN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff       <= '0;
         outer_ff      <= '0;
         inner_ff      <= '0;
         outer_win_ff  <= '0;
         inner_win_ff  <= '0;
         outer_base_ff <= '0;
         inner_base_ff <= '0;
         outer_sub_ff  <= '0;
         inner_sub_ff  <= '0;
      end else begin
         chan_ff       <= chan_in;
         outer_ff      <= outer_in;
         inner_ff      <= inner_in;
         outer_win_ff  <= outer_win_in;
         inner_win_ff  <= inner_win_in;
         outer_base_ff <= outer_base_in;
         inner_base_ff <= inner_base_in;
         outer_sub_ff  <= outer_sub_in;
         inner_sub_ff  <= inner_sub_in;
      end
   end

   always_comb begin
      pos.chan       = chan_ff;
      pos.outer      = outer_ff;
      pos.inner      = inner_ff;
      pos.outer_win  = outer_win_ff;
      pos.inner_win  = inner_win_ff;
      pos.outer_base = outer_base_ff;
      pos.inner_base = inner_base_ff;
      pos.first      = (outer_sub_ff == '0) && (inner_sub_ff == '0);
      // window closes on its last row and column, or at the clipped frame edge
      pos.win_end    = (outer_sub_end || (outer_nx == cfg.outer_extent)) &&
                       (inner_sub_end || (inner_nx == cfg.inner_extent));
   end

endmodule

FILE: src/max_pool_and_upsample_2d.sv
// Streaming 2-D max pooling (mode 0) and block replication (mode 1) over a
// multi-channel feature map fed one sample per item, inner index fastest. One
// item is worked on at a time. In reduce mode the row store of partial maxima
// (a 1024-entry RAM with registered read) is read in the accept cycle, and the
// max unit compares and writes back in ST_MAX; a window-closing item waits
// there until the output register is free. In enlarge mode the replication
// sequencer emits the item's results (up to factor squared), one per cycle
// while the output register is free. The row store has no clearing pass.
// Depends on mpu_pkg, mpu_ram, mpu_pos and the defines header.
`include "max_pool_and_upsample_2d_defines.svh"

module max_pool_and_upsample_2d (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [mpu_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mpu_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic [mpu_pkg::EXT_W-1:0]           rsp_out_outer,
   output logic [mpu_pkg::EXT_W-1:0]           rsp_out_inner,
   output logic signed [mpu_pkg::SAMPLE_W-1:0] rsp_value,
   output logic                                rsp_last_of_burst,
   input  logic                                csr_we,
   input  logic [mpu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mpu_pkg::CSR_W-1:0]           csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAX  = 2'd1;
   localparam logic [1:0] ST_REP  = 2'd2;

   mpu_pkg::cfg_type cfg_ff, cfg_in;
   mpu_pkg::pos_type pos;
   logic             restart, advance;

   logic [1:0] state_ff, state_in;
   logic signed [mpu_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [mpu_pkg::EXT_W-1:0] oo_ff, oo_in, ii_ff, ii_in;
   logic [mpu_pkg::SUB_W-1:0] k_ff, k_in, l_ff, l_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mpu_pkg::CHAN_W-1:0]          rsp_chan_ff, rsp_chan_in;
   logic [mpu_pkg::EXT_W-1:0]           rsp_outer_ff, rsp_outer_in;
   logic [mpu_pkg::EXT_W-1:0]           rsp_inner_ff, rsp_inner_in;
   logic signed [mpu_pkg::SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic accept, out_free, load, load_last;
   logic ram_wr_en, ram_rd_en;
   logic [mpu_pkg::PMAX_W-1:0] ram_rd_data, ram_wr_data;
   logic signed [mpu_pkg::SAMPLE_W-1:0] prior, cur;
   logic [mpu_pkg::FACTOR_W-1:0] f_m1_full;
   logic [mpu_pkg::SUB_W-1:0]    f_m1;
   logic [mpu_pkg::EXTC_W-1:0]   oo_nx, ii_nx;
   logic row_end, last_row;

   // ---------------- configuration ----------------
   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            mpu_pkg::CSR_MODE: begin
               cfg_in.mode = csr_wdata[0];
               restart     = 1'b1;
            end
            mpu_pkg::CSR_FACTOR: begin
               cfg_in.factor = mpu_pkg::clamp_factor(csr_wdata[mpu_pkg::FACTOR_W-1:0]);
               restart       = 1'b1;
            end
            mpu_pkg::CSR_OUTER_EXTENT: begin
               cfg_in.outer_extent = mpu_pkg::clamp_extent(csr_wdata);
               restart             = 1'b1;
            end
            mpu_pkg::CSR_INNER_EXTENT: begin
               cfg_in.inner_extent = mpu_pkg::clamp_extent(csr_wdata);
               restart             = 1'b1;
            end
            mpu_pkg::CSR_CHANNEL_COUNT: begin
               cfg_in.channel_count =
                  mpu_pkg::clamp_chan(csr_wdata[mpu_pkg::CHANC_W-1:0]);
               restart              = 1'b1;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= mpu_pkg::MODE_REDUCE;
         cfg_ff.factor        <= mpu_pkg::FACTOR_W'(2);
         cfg_ff.outer_extent  <= mpu_pkg::EXTC_W'(mpu_pkg::MAX_EXTENT);
         cfg_ff.inner_extent  <= mpu_pkg::EXTC_W'(mpu_pkg::MAX_EXTENT);
         cfg_ff.channel_count <= mpu_pkg::CHANC_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- position and row store ----------------
   mpu_pos u_pos (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .restart (restart),
      .advance (advance),
      .pos     (pos)
   );

   mpu_ram #(
      .WIDTH (mpu_pkg::PMAX_W),
      .DEPTH (mpu_pkg::MAX_EXTENT)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos.inner_win),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pos.inner_win),
      .rd_data (ram_rd_data)
   );

   // ---------------- sequencer ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ram_rd_en = accept && (cfg_ff.mode == mpu_pkg::MODE_REDUCE);

   always_comb begin
      f_m1_full = cfg_ff.factor - mpu_pkg::FACTOR_W'(1);
      f_m1      = f_m1_full[mpu_pkg::SUB_W-1:0];
      // max unit: a window's first sample starts from zero
      prior     = pos.first ? '0 : $signed({1'b0, ram_rd_data});
      cur       = (sample_ff > prior) ? sample_ff : prior;
      ram_wr_data = cur[mpu_pkg::PMAX_W-1:0];
      oo_nx     = {1'b0, oo_ff} + mpu_pkg::EXTC_W'(1);
      ii_nx     = {1'b0, ii_ff} + mpu_pkg::EXTC_W'(1);
      row_end   = (l_ff == f_m1) || (ii_nx >= cfg_ff.inner_extent);
      last_row  = (k_ff == f_m1) || (oo_nx >= cfg_ff.outer_extent);

      state_in     = state_ff;
      sample_in    = sample_ff;
      oo_in        = oo_ff;
      ii_in        = ii_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      advance      = 1'b0;
      ram_wr_en    = 1'b0;
      load         = 1'b0;
      load_last    = 1'b0;
      rsp_chan_in  = pos.chan;
      rsp_outer_in = oo_ff;
      rsp_inner_in = ii_ff;
      rsp_value_in = sample_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               oo_in     = pos.outer_base;
               ii_in     = pos.inner_base;
               k_in      = '0;
               l_in      = '0;
               state_in  = (cfg_ff.mode == mpu_pkg::MODE_REDUCE) ? ST_MAX : ST_REP;
            end
         end
         ST_MAX: begin
            rsp_outer_in = pos.outer_win;
            rsp_inner_in = pos.inner_win;
            rsp_value_in = cur;
            if (!pos.win_end || out_free) begin
               ram_wr_en = 1'b1;
               advance   = 1'b1;
               load      = pos.win_end;
               load_last = pos.win_end;
               state_in  = ST_IDLE;
            end
         end
         ST_REP: begin
            if (out_free) begin
               load = 1'b1;
               if (row_end && last_row) begin
                  load_last = 1'b1;
                  advance   = 1'b1;
                  state_in  = ST_IDLE;
               end else if (row_end) begin
                  oo_in = oo_nx[mpu_pkg::EXT_W-1:0];
                  k_in  = k_ff + mpu_pkg::SUB_W'(1);
                  ii_in = pos.inner_base;
                  l_in  = '0;
               end else begin
                  ii_in = ii_nx[mpu_pkg::EXT_W-1:0];
                  l_in  = l_ff + mpu_pkg::SUB_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_last_in  = load_last;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      oo_ff     <= oo_in;
      ii_ff     <= ii_in;
      k_ff      <= k_in;
      l_ff      <= l_in;
      if (load) begin
         rsp_chan_ff  <= rsp_chan_in;
         rsp_outer_ff <= rsp_outer_in;
         rsp_inner_ff <= rsp_inner_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_chan_ff;
   assign rsp_out_outer     = rsp_outer_ff;
   assign rsp_out_inner     = rsp_inner_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_last_of_burst = rsp_last_ff;

   // ---------------- checks ----------------
   `MPU_ASSERT(a_accept_leaves_idle, accept |=> (state_ff != ST_IDLE), "accepted item did not start work")
   `MPU_ASSERT(a_last_ends_item, (load && load_last) |=> (state_ff == ST_IDLE), "last result of an item did not end it")
   `MPU_ASSERT(a_enlarge_in_frame, (rsp_valid_ff && (cfg_ff.mode == mpu_pkg::MODE_ENLARGE)) |-> (({1'b0, rsp_outer_ff} < cfg_ff.outer_extent) && ({1'b0, rsp_inner_ff} < cfg_ff.inner_extent)), "replicated result outside frame")
   `MPU_ASSERT(a_pool_nonneg, (rsp_valid_ff && (cfg_ff.mode == mpu_pkg::MODE_REDUCE)) |-> !rsp_value_ff[mpu_pkg::SAMPLE_W-1], "pooled result negative")

endmodule
